/* hw/rtl/isapmf_pkg.sv */
// ----------------------------------------------------------------------------
// isapmf_pkg: shared types and constants
// Sizes of the graph stores, item kinds and the datapath command and status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package isapmf_pkg;

	localparam int MAX_NODES  = 128;
	localparam int NODE_BITS  = 7;
	localparam int LABEL_BITS = 8;
	localparam int CAP_BITS   = 30;
	localparam int FLOW_BITS  = CAP_BITS + 1;
	localparam int TOTAL_BITS = 32;
	localparam int MAT_DEPTH  = MAX_NODES * MAX_NODES;
	localparam int MAT_AW     = 2 * NODE_BITS;
	localparam int GAP_DEPTH  = MAX_NODES + 1;
	localparam int GAP_AW     = $clog2(GAP_DEPTH);
	localparam int RES_BITS   = CAP_BITS + 3;

	localparam logic [CAP_BITS-1:0] CAP_MAX = {CAP_BITS{1'b1}};

	localparam logic [1:0] REG_NODE_COUNT = 2'd0;
	localparam logic [1:0] REG_SOURCE     = 2'd1;
	localparam logic [1:0] REG_SINK       = 2'd2;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_READ  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic {
		CAP_W_ZERO = 1'b0,
		CAP_W_ADD  = 1'b1
	} cap_wsel_t;

	typedef enum logic [1:0] {
		FLOW_W_ZERO  = 2'd0,
		FLOW_W_PLUS  = 2'd1,
		FLOW_W_MINUS = 2'd2
	} flow_wsel_t;

	typedef enum logic [1:0] {
		GAP_W_ZERO = 2'd0,
		GAP_W_N    = 2'd1,
		GAP_W_DEC  = 2'd2,
		GAP_W_INC  = 2'd3
	} gap_wsel_t;

	typedef enum logic [2:0] {
		DU_HOLD = 3'd0,
		DU_DEC  = 3'd1,
		DU_DS   = 3'd2,
		DU_M    = 3'd3,
		DU_RAM  = 3'd4
	} du_op_t;

	typedef struct packed {
		logic                  item_load;
		logic                  run_init;
		logic [MAT_AW-1:0]     mat_raddr;
		logic [MAT_AW-1:0]     mat_waddr;
		logic                  cap_we;
		cap_wsel_t             cap_wsel;
		logic                  flow_we;
		flow_wsel_t            flow_wsel;
		logic [NODE_BITS-1:0]  dist_raddr;
		logic                  dist_we;
		logic [NODE_BITS-1:0]  dist_waddr;
		logic                  dist_wm;
		logic                  gap_rm;
		logic                  gap_we;
		gap_wsel_t             gap_wsel;
		logic [GAP_AW-1:0]     gap_waddr;
		logic [NODE_BITS-1:0]  pred_raddr;
		logic                  pred_we;
		logic [NODE_BITS-1:0]  pred_waddr;
		logic [NODE_BITS-1:0]  pred_wdata;
		du_op_t                du_op;
		logic                  ds_load;
		logic                  m_init;
		logic                  scan_chk;
		logic                  gap_cap;
		logic                  bott_init;
		logic                  bott_upd;
		logic                  total_add;
		logic                  ef_cap;
		logic                  out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic                  adm;
		logic                  gap_one;
		logic                  ds_ge_n;
		logic [NODE_BITS-1:0]  pred_rd;
	} dp_status_t;

	function automatic logic [LABEL_BITS-1:0] clamp_nodes(input logic [LABEL_BITS-1:0] v);
		logic [LABEL_BITS-1:0] r;
		r = v;
		if (v < LABEL_BITS'(2)) r = LABEL_BITS'(2);
		if (v > LABEL_BITS'(MAX_NODES)) r = LABEL_BITS'(MAX_NODES);
		return r;
	endfunction

endpackage

/* hw/rtl/isapmf_ram.sv */
// ----------------------------------------------------------------------------
// isapmf_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module isapmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/isapmf_dp.sv */
// ----------------------------------------------------------------------------
// isapmf_dp: flow datapath
// Holds the capacity, flow, label, gap and predecessor stores and the
// arithmetic of residuals, bottleneck, relabel minimum and flow totals.
// ----------------------------------------------------------------------------
module isapmf_dp import isapmf_pkg::*; (
	input  logic                    clk,
	input  dp_cmd_t                 cmd,
	input  logic [LABEL_BITS-1:0]   node_n,
	input  logic [CAP_BITS-1:0]     cap_in,
	output dp_status_t              status,
	output logic [TOTAL_BITS-1:0]   out_total,
	output logic [FLOW_BITS-1:0]    out_edge
);

	logic [CAP_BITS-1:0]          cap_rd, cap_wdata, cap_in_q;
	logic [FLOW_BITS-1:0]         flow_rd, flow_wdata, ef_q;
	logic [LABEL_BITS-1:0]        dist_rd, dist_wdata;
	logic [LABEL_BITS-1:0]        gap_rd, gap_wdata, gap_q;
	logic [GAP_AW-1:0]            gap_raddr, gap_waddr;
	logic [NODE_BITS-1:0]         pred_rd;
	logic [LABEL_BITS-1:0]        du_q, ds_q, m_q;
	logic [LABEL_BITS:0]          dv_inc;
	logic [CAP_BITS:0]            cap_sum;
	logic signed [RES_BITS-1:0]   cap_ext, flow_ext, res, bott_q, bott_eff;
	logic                         pos;
	logic [TOTAL_BITS-1:0]        total_q;
	logic [TOTAL_BITS:0]          tsum;

	isapmf_ram #(.WIDTH(CAP_BITS), .DEPTH(MAT_DEPTH)) u_cap_ram (
		.clk(clk), .we(cmd.cap_we), .waddr(cmd.mat_waddr), .wdata(cap_wdata),
		.raddr(cmd.mat_raddr), .rdata(cap_rd)
	);

	isapmf_ram #(.WIDTH(FLOW_BITS), .DEPTH(MAT_DEPTH)) u_flow_ram (
		.clk(clk), .we(cmd.flow_we), .waddr(cmd.mat_waddr), .wdata(flow_wdata),
		.raddr(cmd.mat_raddr), .rdata(flow_rd)
	);

	isapmf_ram #(.WIDTH(LABEL_BITS), .DEPTH(MAX_NODES)) u_dist_ram (
		.clk(clk), .we(cmd.dist_we), .waddr(cmd.dist_waddr), .wdata(dist_wdata),
		.raddr(cmd.dist_raddr), .rdata(dist_rd)
	);

	isapmf_ram #(.WIDTH(LABEL_BITS), .DEPTH(GAP_DEPTH)) u_gap_ram (
		.clk(clk), .we(cmd.gap_we), .waddr(gap_waddr), .wdata(gap_wdata),
		.raddr(gap_raddr), .rdata(gap_rd)
	);

	isapmf_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_pred_ram (
		.clk(clk), .we(cmd.pred_we), .waddr(cmd.pred_waddr), .wdata(cmd.pred_wdata),
		.raddr(cmd.pred_raddr), .rdata(pred_rd)
	);

	assign cap_ext  = RES_BITS'(cap_rd);
	assign flow_ext = RES_BITS'(signed'(flow_rd));
	assign res      = cap_ext - flow_ext;
	assign pos      = (res != '0) && !res[RES_BITS-1];
	assign dv_inc   = {1'b0, dist_rd} + (LABEL_BITS+1)'(1);
	assign bott_eff = bott_q[RES_BITS-1] ? '0 : bott_q;
	assign cap_sum  = {1'b0, cap_rd} + {1'b0, cap_in_q};
	assign tsum     = {1'b0, total_q} + {1'b0, bott_eff[TOTAL_BITS-1:0]};

	always_comb begin
		cap_wdata = '0;
		if (cmd.cap_wsel == CAP_W_ADD) begin
			cap_wdata = cap_sum[CAP_BITS] ? CAP_MAX : cap_sum[CAP_BITS-1:0];
		end
		case (cmd.flow_wsel)
			FLOW_W_PLUS:  flow_wdata = FLOW_BITS'(flow_ext + bott_eff);
			FLOW_W_MINUS: flow_wdata = FLOW_BITS'(flow_ext - bott_eff);
			default:      flow_wdata = '0;
		endcase
		dist_wdata = cmd.dist_wm ? m_q : '0;
		gap_raddr  = cmd.gap_rm ? GAP_AW'(m_q) : GAP_AW'(du_q);
		case (cmd.gap_wsel)
			GAP_W_N: begin
				gap_waddr = '0;
				gap_wdata = node_n;
			end
			GAP_W_DEC: begin
				gap_waddr = GAP_AW'(du_q);
				gap_wdata = gap_q - LABEL_BITS'(1);
			end
			GAP_W_INC: begin
				gap_waddr = GAP_AW'(m_q);
				gap_wdata = gap_rd + LABEL_BITS'(1);
			end
			default: begin
				gap_waddr = cmd.gap_waddr;
				gap_wdata = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			cap_in_q <= cap_in;
			total_q  <= '0;
			ef_q     <= '0;
		end
		if (cmd.run_init) begin
			du_q <= '0;
			ds_q <= '0;
		end else begin
			case (cmd.du_op)
				DU_DEC:  du_q <= du_q - LABEL_BITS'(1);
				DU_DS:   du_q <= ds_q;
				DU_M:    du_q <= m_q;
				DU_RAM:  du_q <= dist_rd;
				default: du_q <= du_q;
			endcase
			if (cmd.ds_load) begin
				ds_q <= m_q;
			end
		end
		if (cmd.m_init) begin
			m_q <= node_n;
		end else if (cmd.scan_chk && pos && (dv_inc < {1'b0, m_q})) begin
			m_q <= dv_inc[LABEL_BITS-1:0];
		end
		if (cmd.gap_cap) begin
			gap_q <= gap_rd;
		end
		if (cmd.bott_init) begin
			bott_q <= '1;
		end else if (cmd.bott_upd && (bott_q[RES_BITS-1] || (res < bott_q))) begin
			bott_q <= res;
		end
		if (cmd.total_add) begin
			total_q <= tsum[TOTAL_BITS] ? '1 : tsum[TOTAL_BITS-1:0];
		end
		if (cmd.ef_cap) begin
			ef_q <= (flow_rd == {1'b1, {(FLOW_BITS-1){1'b0}}}) ?
				{1'b1, {(FLOW_BITS-2){1'b0}}, 1'b1} : flow_rd;
		end
		if (cmd.out_load) begin
			out_total <= total_q;
			out_edge  <= ef_q;
		end
	end

	assign status.adm     = pos && (dv_inc == {1'b0, du_q});
	assign status.gap_one = (gap_rd == LABEL_BITS'(1));
	assign status.ds_ge_n = (ds_q >= node_n);
	assign status.pred_rd = pred_rd;

endmodule

/* hw/rtl/isapmf_ctrl.sv */
// ----------------------------------------------------------------------------
// isapmf_ctrl: flow controller
// Sequences store sweeps, edge updates, the search loop, relabeling,
// retreats and augmentation, and owns the item and result handshakes.
// ----------------------------------------------------------------------------
module isapmf_ctrl import isapmf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [1:0]             mode_in,
	input  logic [NODE_BITS-1:0]   from_in,
	input  logic [NODE_BITS-1:0]   to_in,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [LABEL_BITS-1:0]  node_n,
	input  logic [NODE_BITS-1:0]   source_node,
	input  logic [NODE_BITS-1:0]   sink_node,
	output dp_cmd_t                cmd,
	input  dp_status_t             status
);

	typedef enum logic [4:0] {
		ST_RST_CLR, ST_IDLE, ST_ADD_RD, ST_ADD_WR, ST_RD_RD, ST_RD_CAP, ST_CAP_CLR,
		ST_FL_CLR, ST_INIT, ST_HEAD, ST_SCAN_F, ST_GAP_RD, ST_GAP_CHK, ST_SCAN_M,
		ST_RELAB, ST_GAP_RDM, ST_GAP_INC, ST_RET_RD, ST_RET_U, ST_RET_D,
		ST_A1_HEAD, ST_A1_P, ST_A1_R, ST_A2_HEAD, ST_A2_P, ST_A2_F1, ST_A2_F2,
		ST_DONE
	} state_t;

	state_t                 state_q, state_d;
	logic [MAT_AW-1:0]      clr_q, clr_d;
	logic [NODE_BITS-1:0]   a_q, a_d, b_q, b_d, u_q, u_d, w_q, w_d, p_q, p_d;
	logic [NODE_BITS-1:0]   chk_v_q, chk_v_d;
	logic [LABEL_BITS-1:0]  vi_q, vi_d, steps_q, steps_d;
	logic                   chk_vld_q, chk_vld_d, out_vld_q, out_vld_d;
	logic [NODE_BITS-1:0]   n_m1;
	logic                   scan_last, bad_ends;

	assign n_m1      = NODE_BITS'(node_n - LABEL_BITS'(1));
	assign scan_last = chk_vld_q && (chk_v_q == n_m1);
	assign bad_ends  = ({1'b0, source_node} >= node_n) || ({1'b0, sink_node} >= node_n) ||
		(source_node == sink_node);
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_vld_q;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		clr_d     = clr_q;
		a_d       = a_q;
		b_d       = b_q;
		u_d       = u_q;
		w_d       = w_q;
		p_d       = p_q;
		chk_v_d   = chk_v_q;
		chk_vld_d = 1'b0;
		vi_d      = vi_q;
		steps_d   = steps_q;
		case (state_q)
			ST_RST_CLR: begin
				cmd.cap_we    = 1'b1;
				cmd.flow_we   = 1'b1;
				cmd.mat_waddr = clr_q;
				clr_d         = clr_q + MAT_AW'(1);
				if (&clr_q) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.item_load = 1'b1;
					a_d           = from_in;
					b_d           = to_in;
					clr_d         = '0;
					case (mode_t'(mode_in))
						MODE_ADD:  state_d = ST_ADD_RD;
						MODE_RUN:  state_d = ST_FL_CLR;
						MODE_READ: state_d = ST_RD_RD;
						default:   state_d = ST_CAP_CLR;
					endcase
				end
			end
			ST_ADD_RD: begin
				cmd.mat_raddr = {a_q, b_q};
				state_d       = ST_ADD_WR;
			end
			ST_ADD_WR: begin
				cmd.cap_we    = 1'b1;
				cmd.cap_wsel  = CAP_W_ADD;
				cmd.mat_waddr = {a_q, b_q};
				state_d       = ST_DONE;
			end
			ST_RD_RD: begin
				cmd.mat_raddr = {a_q, b_q};
				state_d       = ST_RD_CAP;
			end
			ST_RD_CAP: begin
				cmd.ef_cap = 1'b1;
				state_d    = ST_DONE;
			end
			ST_CAP_CLR: begin
				cmd.cap_we    = 1'b1;
				cmd.mat_waddr = clr_q;
				clr_d         = clr_q + MAT_AW'(1);
				if (&clr_q) state_d = ST_DONE;
			end
			ST_FL_CLR: begin
				cmd.flow_we    = 1'b1;
				cmd.mat_waddr  = clr_q;
				cmd.dist_waddr = clr_q[NODE_BITS-1:0];
				cmd.pred_waddr = clr_q[NODE_BITS-1:0];
				cmd.gap_waddr  = clr_q[GAP_AW-1:0];
				cmd.dist_we    = (clr_q[MAT_AW-1:NODE_BITS] == '0);
				cmd.pred_we    = (clr_q[MAT_AW-1:NODE_BITS] == '0);
				cmd.gap_we     = (clr_q[MAT_AW-1:GAP_AW] == '0) &&
					(!clr_q[GAP_AW-1] || (clr_q[GAP_AW-2:0] == '0));
				clr_d          = clr_q + MAT_AW'(1);
				if (&clr_q) state_d = ST_INIT;
			end
			ST_INIT: begin
				cmd.run_init = 1'b1;
				if (bad_ends) begin
					state_d = ST_DONE;
				end else begin
					cmd.gap_we   = 1'b1;
					cmd.gap_wsel = GAP_W_N;
					u_d          = source_node;
					state_d      = ST_HEAD;
				end
			end
			ST_HEAD: begin
				vi_d = '0;
				if (status.ds_ge_n) state_d = ST_DONE;
				else state_d = ST_SCAN_F;
			end
			ST_SCAN_F, ST_SCAN_M: begin
				cmd.mat_raddr  = {u_q, vi_q[NODE_BITS-1:0]};
				cmd.dist_raddr = vi_q[NODE_BITS-1:0];
				cmd.scan_chk   = (state_q == ST_SCAN_M) && chk_vld_q;
				chk_vld_d      = (vi_q < node_n);
				chk_v_d        = vi_q[NODE_BITS-1:0];
				vi_d           = vi_q + LABEL_BITS'(1);
				if (state_q == ST_SCAN_F && chk_vld_q && status.adm) begin
					chk_vld_d      = 1'b0;
					cmd.pred_we    = 1'b1;
					cmd.pred_waddr = chk_v_q;
					cmd.pred_wdata = u_q;
					cmd.du_op      = DU_DEC;
					u_d            = chk_v_q;
					if (chk_v_q == sink_node) begin
						cmd.bott_init = 1'b1;
						w_d           = sink_node;
						steps_d       = '0;
						state_d       = ST_A1_HEAD;
					end else begin
						state_d = ST_HEAD;
					end
				end else if (scan_last) begin
					chk_vld_d = 1'b0;
					state_d   = (state_q == ST_SCAN_F) ? ST_GAP_RD : ST_RELAB;
				end
			end
			ST_GAP_RD: begin
				state_d = ST_GAP_CHK;
			end
			ST_GAP_CHK: begin
				cmd.gap_cap = 1'b1;
				if (status.gap_one) begin
					state_d = ST_DONE;
				end else begin
					cmd.m_init = 1'b1;
					vi_d       = '0;
					state_d    = ST_SCAN_M;
				end
			end
			ST_RELAB: begin
				cmd.gap_we     = 1'b1;
				cmd.gap_wsel   = GAP_W_DEC;
				cmd.dist_we    = 1'b1;
				cmd.dist_wm    = 1'b1;
				cmd.dist_waddr = u_q;
				state_d        = ST_GAP_RDM;
			end
			ST_GAP_RDM: begin
				cmd.gap_rm = 1'b1;
				state_d    = ST_GAP_INC;
			end
			ST_GAP_INC: begin
				cmd.gap_we   = 1'b1;
				cmd.gap_wsel = GAP_W_INC;
				cmd.du_op    = DU_M;
				if (u_q == source_node) begin
					cmd.ds_load = 1'b1;
					state_d     = ST_HEAD;
				end else begin
					state_d = ST_RET_RD;
				end
			end
			ST_RET_RD: begin
				cmd.pred_raddr = u_q;
				state_d        = ST_RET_U;
			end
			ST_RET_U: begin
				u_d            = status.pred_rd;
				cmd.dist_raddr = status.pred_rd;
				state_d        = ST_RET_D;
			end
			ST_RET_D: begin
				cmd.du_op = DU_RAM;
				state_d   = ST_HEAD;
			end
			ST_A1_HEAD: begin
				cmd.pred_raddr = w_q;
				if (w_q == source_node || steps_q >= node_n) begin
					w_d     = sink_node;
					steps_d = '0;
					state_d = ST_A2_HEAD;
				end else begin
					state_d = ST_A1_P;
				end
			end
			ST_A1_P: begin
				p_d           = status.pred_rd;
				cmd.mat_raddr = {status.pred_rd, w_q};
				state_d       = ST_A1_R;
			end
			ST_A1_R: begin
				cmd.bott_upd = 1'b1;
				w_d          = p_q;
				steps_d      = steps_q + LABEL_BITS'(1);
				state_d      = ST_A1_HEAD;
			end
			ST_A2_HEAD: begin
				cmd.pred_raddr = w_q;
				if (w_q == source_node || steps_q >= node_n) begin
					cmd.total_add = 1'b1;
					cmd.du_op     = DU_DS;
					u_d           = source_node;
					state_d       = ST_HEAD;
				end else begin
					state_d = ST_A2_P;
				end
			end
			ST_A2_P: begin
				p_d           = status.pred_rd;
				cmd.mat_raddr = {status.pred_rd, w_q};
				state_d       = ST_A2_F1;
			end
			ST_A2_F1: begin
				cmd.flow_we   = 1'b1;
				cmd.flow_wsel = FLOW_W_PLUS;
				cmd.mat_waddr = {p_q, w_q};
				cmd.mat_raddr = {w_q, p_q};
				state_d       = ST_A2_F2;
			end
			ST_A2_F2: begin
				cmd.flow_we   = 1'b1;
				cmd.flow_wsel = FLOW_W_MINUS;
				cmd.mat_waddr = {w_q, p_q};
				w_d           = p_q;
				steps_d       = steps_q + LABEL_BITS'(1);
				state_d       = ST_A2_HEAD;
			end
			ST_DONE: begin
				if (!out_vld_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (cmd.out_load) out_vld_d = 1'b1;
		else if (m_tready) out_vld_d = 1'b0;
		else out_vld_d = out_vld_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RST_CLR;
			clr_q     <= '0;
			a_q       <= '0;
			b_q       <= '0;
			u_q       <= '0;
			w_q       <= '0;
			p_q       <= '0;
			chk_v_q   <= '0;
			chk_vld_q <= 1'b0;
			vi_q      <= '0;
			steps_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_q     <= clr_d;
			a_q       <= a_d;
			b_q       <= b_d;
			u_q       <= u_d;
			w_q       <= w_d;
			p_q       <= p_d;
			chk_v_q   <= chk_v_d;
			chk_vld_q <= chk_vld_d;
			vi_q      <= vi_d;
			steps_q   <= steps_d;
			out_vld_q <= out_vld_d;
		end
	end

endmodule

/* hw/rtl/isap_max_flow.sv */
// ----------------------------------------------------------------------------
// isap_max_flow: maximum flow engine with the gap heuristic
// Dense capacity graph, edge loads, flow reads, capacity clears and flow runs.
// ----------------------------------------------------------------------------
// Requests enter on the s_ group; the kind travels in s_tuser and the edge and
// amount in s_tdata. Every request returns exactly one result on the m_ group.
// Registers node_count, source_node and sink_node sit on the APB port at 0x0,
// 0x4 and 0x8 and are to be written only while the block is idle; the block
// itself does not enforce this.
// After reset the block sweeps the capacity and flow stores to zero, one entry
// per cycle, before s_tready rises.
// An edge load reads the capacity entry and writes back the saturated sum; an
// edge read captures the flow entry; both then load the result register.
// A clear of all capacities zeroes the capacity store, one entry per cycle.
// A flow run clears the flow store, then walks the graph: a relabel adds a
// second neighbor scan, a retreat steps back to the predecessor, and an
// augmentation walks the path once for the bottleneck and once for the flows.
// One request is worked on at a time; a finished result waits in the output
// register while the next request is taken. If the receiver stalls, the next
// result is held back until the register empties.
// ----------------------------------------------------------------------------
module isap_max_flow import isapmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // from_node[6:0], to_node[13:7], capacity[43:14], zero
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // total_flow[31:0], edge_flow[62:32], zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [LABEL_BITS-1:0]  node_count_q, node_n;
	logic [NODE_BITS-1:0]   source_q, sink_q;
	logic [TOTAL_BITS-1:0]  out_total;
	logic [FLOW_BITS-1:0]   out_edge;
	dp_cmd_t                cmd;
	dp_status_t             status;
	logic                   wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign node_n = clamp_nodes(node_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= LABEL_BITS'(MAX_NODES);
			source_q     <= '0;
			sink_q       <= NODE_BITS'(1);
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_NODE_COUNT: node_count_q <= pwdata[LABEL_BITS-1:0];
				REG_SOURCE:     source_q     <= pwdata[NODE_BITS-1:0];
				REG_SINK:       sink_q       <= pwdata[NODE_BITS-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_NODE_COUNT: prdata = 32'(node_count_q);
			REG_SOURCE:     prdata = 32'(source_q);
			REG_SINK:       prdata = 32'(sink_q);
			default:        prdata = '0;
		endcase
	end

	isapmf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.mode_in(s_tuser),
		.from_in(s_tdata[6:0]),
		.to_in(s_tdata[13:7]),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.node_n(node_n),
		.source_node(source_q),
		.sink_node(sink_q),
		.cmd(cmd),
		.status(status)
	);

	isapmf_dp u_dp (
		.clk(clk),
		.cmd(cmd),
		.node_n(node_n),
		.cap_in(s_tdata[43:14]),
		.status(status),
		.out_total(out_total),
		.out_edge(out_edge)
	);

	assign m_tdata = {1'b0, out_edge, out_total};

endmodule

/* hw/rtl/isapmf_chk.sv */
// ----------------------------------------------------------------------------
// isapmf_chk: port checker
// Watches the request and result channels of the flow engine over time.
// ----------------------------------------------------------------------------
module isapmf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in work");

	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result appeared while a request was still in work");

	a_edge_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[62:32] != 31'h40000000)
		else $error("edge flow outside its saturated range");

	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[31:0] == 32'd0 || m_tdata[62:32] == 31'd0))
		else $error("total and edge flow both nonzero");

endmodule

bind isap_max_flow isapmf_chk u_isapmf_chk (.*);

/* dv/isap_flow_checker.sv */
// ----------------------------------------------------------------------------
// isap_flow_checker: result predictor and scoreboard for isap_max_flow
// Watches the APB register writes, the request stream and the result stream.
// It keeps its own capacity and flow graph, recomputes every flow run, and
// compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module isap_flow_checker import isapmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [TOTAL_BITS-1:0] total_flow;
		logic [FLOW_BITS-1:0]  edge_flow;
	} flow_result_t;

	localparam longint EDGE_LIMIT = 64'sd1073741823;

	logic [CAP_BITS-1:0] cap_mat [MAT_DEPTH];
	longint              flow_mat [MAT_DEPTH];
	int                  label [MAX_NODES];
	int                  gap_cnt [GAP_DEPTH];
	int                  pred [MAX_NODES];
	logic [7:0]          cfg_nodes;
	logic [6:0]          cfg_src;
	logic [6:0]          cfg_snk;
	flow_result_t        expected_q [$];

	function automatic longint resid(int u, int v);
		return longint'({34'd0, cap_mat[u * MAX_NODES + v]}) - flow_mat[u * MAX_NODES + v];
	endfunction

	function automatic logic [TOTAL_BITS-1:0] isap_run();
		int n, s, t, u, v, w, steps, p, m;
		bit found;
		longint bott, r;
		longint unsigned total;
		n = cfg_nodes;
		s = cfg_src;
		t = cfg_snk;
		total = 0;
		if (n < 2) n = 2;
		if (n > MAX_NODES) n = MAX_NODES;
		foreach (flow_mat[i]) flow_mat[i] = 0;
		foreach (label[i]) label[i] = 0;
		foreach (gap_cnt[i]) gap_cnt[i] = 0;
		foreach (pred[i]) pred[i] = 0;
		if (s >= n || t >= n || s == t) return '0;
		gap_cnt[0] = n;
		u = s;
		while (label[s] < n) begin
			found = 0;
			for (v = 0; v < n; v++) begin
				if (resid(u, v) > 0 && label[v] + 1 == label[u]) begin
					found = 1;
					break;
				end
			end
			if (found) begin
				pred[v] = u;
				u = v;
				if (u == t) begin
					bott = -1;
					w = t;
					steps = 0;
					while (w != s && steps < n) begin
						r = resid(pred[w], w);
						if (bott < 0 || r < bott) bott = r;
						w = pred[w];
						steps++;
					end
					if (bott < 0) bott = 0;
					w = t;
					steps = 0;
					while (w != s && steps < n) begin
						p = pred[w];
						flow_mat[p * MAX_NODES + w] += bott;
						flow_mat[w * MAX_NODES + p] -= bott;
						w = p;
						steps++;
					end
					total += longint'(bott);
					u = s;
				end
			end else begin
				m = n;
				if (gap_cnt[label[u]] == 1) break;
				for (v = 0; v < n; v++) begin
					if (resid(u, v) > 0 && label[v] + 1 < m) m = label[v] + 1;
				end
				gap_cnt[label[u]]--;
				label[u] = m;
				gap_cnt[m]++;
				if (u != s) u = pred[u];
			end
		end
		return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
	endfunction

	function automatic flow_result_t predict_request(mode_t mode, int a, int b,
		logic [CAP_BITS-1:0] c);
		flow_result_t res;
		logic [CAP_BITS-1:0] cur;
		longint f;
		res = '0;
		case (mode)
			MODE_ADD: begin
				cur = cap_mat[a * MAX_NODES + b];
				cap_mat[a * MAX_NODES + b] = (c > CAP_MAX - cur) ? CAP_MAX : cur + c;
			end
			MODE_RUN: begin
				res.total_flow = isap_run();
			end
			MODE_READ: begin
				f = flow_mat[a * MAX_NODES + b];
				if (f > EDGE_LIMIT) f = EDGE_LIMIT;
				if (f < -EDGE_LIMIT) f = -EDGE_LIMIT;
				res.edge_flow = f[FLOW_BITS-1:0];
			end
			default: begin
				foreach (cap_mat[i]) cap_mat[i] = '0;
			end
		endcase
		return res;
	endfunction

	initial begin
		foreach (cap_mat[i]) cap_mat[i] = '0;
		foreach (flow_mat[i]) flow_mat[i] = 0;
		cfg_nodes = 8'd128;
		cfg_src = 7'd0;
		cfg_snk = 7'd1;
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		flow_result_t exp_r;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_NODE_COUNT: cfg_nodes = pwdata[7:0];
					REG_SOURCE:     cfg_src = pwdata[6:0];
					REG_SINK:       cfg_snk = pwdata[6:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				expected_q.push_back(predict_request(mode_t'(s_tuser), s_tdata[6:0],
					s_tdata[13:7], s_tdata[43:14]));
			end
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("result with no request outstanding: %h", m_tdata);
					fail_count++;
				end else begin
					exp_r = expected_q.pop_front();
					if (m_tdata[31:0] !== exp_r.total_flow) begin
						$error("total_flow expected %0d actual %0d", exp_r.total_flow,
							m_tdata[31:0]);
						fail_count++;
					end
					if (m_tdata[62:32] !== exp_r.edge_flow) begin
						$error("edge_flow expected %0d actual %0d",
							$signed(exp_r.edge_flow), $signed(m_tdata[62:32]));
						fail_count++;
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for isap_max_flow
// Drives a directed set of edge loads, reads, clears and flow runs over the
// corner cases, then random phases of graph building, a flow run and reads,
// each under its own register setting, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb import isapmf_pkg::*;;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	bit          quiet;
	bit          hold_req;
	int          req_count;
	int          run_count;
	int          phase_count;

	isap_max_flow u_top (.*);

	isap_flow_checker u_chk (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#40000000;
		$display("tb: errors");
		$finish;
	end

	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_req = 0;
			end else begin
				m_tready <= quiet || ($urandom_range(0, 99) >= 30);
			end
		end
	end

	task automatic send_request(mode_t mode, logic [6:0] a, logic [6:0] b,
		logic [CAP_BITS-1:0] c);
		while (!quiet && $urandom_range(0, 99) < 30) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {4'd0, c, b, a};
		do @(posedge clk); while (!s_tready);
		req_count++;
		if (mode == MODE_RUN) run_count++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_graph(logic [7:0] n, logic [6:0] s, logic [6:0] t);
		drain();
		write_reg(REG_NODE_COUNT, {24'd0, n});
		write_reg(REG_SOURCE, {25'd0, s});
		write_reg(REG_SINK, {25'd0, t});
	endtask

	task automatic random_phase();
		int n_items, hi, k, pick;
		logic [7:0] n;
		logic [6:0] s, t;
		pick = $urandom_range(0, 15);
		case (pick)
			0: n = 8'd128;
			1: n = 8'd2;
			2: n = 8'($urandom_range(0, 1));
			3: n = 8'($urandom_range(129, 255));
			default: n = 8'($urandom_range(3, 10));
		endcase
		hi = (n < 2) ? 1 : (n > MAX_NODES) ? MAX_NODES - 1 : n - 1;
		s = 7'($urandom_range(0, hi));
		t = 7'($urandom_range(0, hi));
		if ($urandom_range(0, 9) == 0) t = 7'($urandom_range(0, 127));
		if ($urandom_range(0, 7) == 0) begin
			s = 7'd127;
			t = 7'd0;
		end
		set_graph(n, s, t);
		if (phase_count == 3) hold_req = 1;
		if ($urandom_range(0, 3) == 0)
			send_request(MODE_CLEAR, 7'($urandom), 7'($urandom), 30'($urandom));
		n_items = $urandom_range(40, 80);
		for (k = 0; k < n_items; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				send_request(MODE_ADD, 7'($urandom_range(0, hi)),
					7'($urandom_range(0, hi)),
					($urandom_range(0, 3) == 0) ? 30'($urandom) :
					30'($urandom_range(0, 1000)));
			else if (pick < 70)
				send_request(MODE_ADD, 7'($urandom), 7'($urandom), 30'($urandom));
			else
				send_request(MODE_READ, 7'($urandom), 7'($urandom), 30'($urandom));
		end
		send_request(MODE_RUN, 7'($urandom), 7'($urandom), 30'($urandom));
		for (k = 0; k < 10; k++)
			send_request(MODE_READ, 7'($urandom_range(0, hi)), 7'($urandom_range(0, hi)),
				30'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		quiet = 0;
		hold_req = 0;
		req_count = 0;
		run_count = 0;
		phase_count = 0;
		repeat (8) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Reset registers: the full node count with source 0 and sink 1.
		send_request(MODE_ADD, 7'd0, 7'd1, 30'd77);
		send_request(MODE_RUN, 7'd0, 7'd0, 30'd0);
		send_request(MODE_READ, 7'd0, 7'd1, 30'd0);

		// A small graph with a saturated edge and a wide bottleneck choice.
		set_graph(8'd4, 7'd0, 7'd3);
		send_request(MODE_ADD, 7'd0, 7'd1, CAP_MAX);
		send_request(MODE_ADD, 7'd0, 7'd1, 30'd5);
		send_request(MODE_ADD, 7'd1, 7'd3, 30'd7);
		send_request(MODE_ADD, 7'd0, 7'd2, 30'd3);
		send_request(MODE_ADD, 7'd2, 7'd3, CAP_MAX);
		send_request(MODE_ADD, 7'd2, 7'd1, 30'd1);
		send_request(MODE_ADD, 7'd127, 7'd127, 30'd9);
		send_request(MODE_ADD, 7'd0, 7'd127, 30'd9);
		send_request(MODE_RUN, 7'd0, 7'd0, 30'd0);
		send_request(MODE_READ, 7'd0, 7'd1, 30'd0);
		send_request(MODE_READ, 7'd1, 7'd0, 30'd0);
		send_request(MODE_READ, 7'd0, 7'd127, 30'd0);
		send_request(MODE_READ, 7'd2, 7'd3, 30'd0);
		send_request(MODE_CLEAR, 7'd127, 7'd127, CAP_MAX);
		send_request(MODE_READ, 7'd0, 7'd1, 30'd0);
		send_request(MODE_RUN, 7'd0, 7'd0, 30'd0);
		send_request(MODE_READ, 7'd0, 7'd1, 30'd0);

		// Source equal to sink, then a clamped node count with the source outside it.
		set_graph(8'd4, 7'd2, 7'd2);
		send_request(MODE_RUN, 7'd0, 7'd0, 30'd0);
		set_graph(8'd1, 7'd5, 7'd1);
		send_request(MODE_RUN, 7'd0, 7'd0, 30'd0);

		while (req_count < 1810) begin
			phase_count++;
			quiet = (phase_count >= 6 && phase_count <= 9);
			random_phase();
		end
		drain();
		repeat (50) @(posedge clk);
		$display("tb: %0d requests, %0d flow runs over %0d register settings",
			req_count, run_count, phase_count + 4);
		if (fail_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
